[design/assert_macros.svh]
// Assertion macros used by the control endpoint RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[design/ucdc_pkg.sv]
// Codes, types and constant tables of the USB CDC control endpoint.
`timescale 1ns / 1ps

package ucdc_pkg;

  typedef enum logic [2:0] {
    CMD_SETUP     = 3'd0,
    CMD_EP0_IN    = 3'd1,
    CMD_EP0_OUT   = 3'd2,
    CMD_DATA_IN   = 3'd3,
    CMD_BUS_RESET = 3'd4,
    CMD_DISCONN   = 3'd5,
    CMD_TRANSMIT  = 3'd6,
    CMD_DATA_OUT  = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    EP0_NONE  = 3'd0,
    EP0_ZLP   = 3'd1,
    EP0_SEND  = 3'd2,
    EP0_STALL = 3'd3,
    EP0_ARM7  = 3'd4
  } ep0_act_t;

  typedef enum logic [3:0] {
    SRC_NONE     = 4'd0,
    SRC_DEVICE   = 4'd1,
    SRC_CONFIG   = 4'd2,
    SRC_QUAL     = 4'd3,
    SRC_STRING0  = 4'd4,
    SRC_CFG_VAL  = 4'd8,
    SRC_STATUS   = 4'd9,
    SRC_ALT      = 4'd10,
    SRC_LINECODE = 4'd11
  } src_t;

  typedef enum logic [2:0] {
    EPA_NONE   = 3'd0,
    EPA_OPEN   = 3'd1,
    EPA_CLOSE  = 3'd2,
    EPA_EP0    = 3'd3,
    EPA_REARM  = 3'd4
  } ep_act_t;

  typedef enum logic [1:0] {
    TX_NONE    = 2'd0,
    TX_ACCEPT  = 2'd1,
    TX_REFUSED = 2'd2
  } tx_stat_t;

  // Request types (bits 6:5) and recipients (bits 4:0) of bmRequestType
  localparam logic [1:0] KIND_STANDARD = 2'b00;
  localparam logic [1:0] KIND_CLASS    = 2'b01;
  localparam logic [4:0] RCP_DEVICE    = 5'd0;
  localparam logic [4:0] RCP_INTERFACE = 5'd1;

  // Standard requests
  localparam logic [7:0] REQ_GET_STATUS    = 8'h00;
  localparam logic [7:0] REQ_CLEAR_FEATURE = 8'h01;
  localparam logic [7:0] REQ_SET_FEATURE   = 8'h03;
  localparam logic [7:0] REQ_SET_ADDRESS   = 8'h05;
  localparam logic [7:0] REQ_GET_DESC      = 8'h06;
  localparam logic [7:0] REQ_GET_CONFIG    = 8'h08;
  localparam logic [7:0] REQ_SET_CONFIG    = 8'h09;
  localparam logic [7:0] REQ_GET_IFACE     = 8'h0A;
  localparam logic [7:0] REQ_SET_IFACE     = 8'h0B;

  // CDC class requests
  localparam logic [7:0] REQ_SET_LINE_CODING = 8'h20;
  localparam logic [7:0] REQ_GET_LINE_CODING = 8'h21;
  localparam logic [7:0] REQ_SET_CTRL_LINE   = 8'h22;
  localparam logic [7:0] REQ_SEND_BREAK      = 8'h23;

  // Descriptor types
  localparam logic [7:0] DESC_DEVICE = 8'h01;
  localparam logic [7:0] DESC_CONFIG = 8'h02;
  localparam logic [7:0] DESC_STRING = 8'h03;
  localparam logic [7:0] DESC_QUAL   = 8'h06;

  // Reply sizes in bytes
  localparam logic [6:0] LEN_DEVICE   = 7'd18;
  localparam logic [6:0] LEN_CONFIG   = 7'd75;
  localparam logic [6:0] LEN_QUAL     = 7'd10;
  localparam logic [6:0] LEN_CFG_VAL  = 7'd1;
  localparam logic [6:0] LEN_STATUS   = 7'd2;
  localparam logic [6:0] LEN_ALT      = 7'd1;
  localparam logic [6:0] LEN_LINECODE = 7'd7;
  localparam int unsigned NUM_STRINGS = 4;

  localparam logic [31:0] DEFAULT_RATE      = 32'd9600;
  localparam logic [7:0]  DEFAULT_DATA_BITS = 8'd8;

  // Size of string descriptor idx
  function automatic logic [6:0] string_len(input logic [1:0] idx);
    logic [6:0] len;
    case (idx)
      2'd0:    len = 7'd4;
      2'd1:    len = 7'd14;
      2'd2:    len = 7'd26;
      default: len = 7'd10;
    endcase
    return len;
  endfunction

  // Reply size clamped to wLength
  function automatic logic [6:0] clamp_len(input logic [6:0] size, input logic [15:0] wlen);
    logic [6:0] len;
    if (wlen < {9'd0, size}) len = wlen[6:0];
    else len = size;
    return len;
  endfunction

endpackage

[design/usb_cdc_control_endpoint.sv]
// USB CDC ACM control endpoint: event decoder, request handler and state keeper.
//
//   channel  | direction | word
//   ---------+-----------+------------------------------------------------
//   s_axis   | in        | one device event (kind in tuser, request in tdata)
//   m_axis   | out       | one reply/action word per event
//
// Each event passes from the input register to the result register. One
// event is accepted per cycle while the result register is not stalled.
// The decode between the two registers is a few compares and muxes.
// A stalled result register holds its word; the input register still fills,
// and s_axis_tready drops only when both stages hold a word.
// rst (synchronous, active high) clears the valid flags and the endpoint
// state to its power-on values (line rate 9600, 8 data bits).
`timescale 1ns / 1ps
`include "assert_macros.svh"

module usb_cdc_control_endpoint (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [7:0] setup_type, [15:8] request_code, [31:16] request_value,
  // [47:32] request_length, [79:48] coding_rate, [87:80] coding_stop_bits,
  // [95:88] coding_parity, [103:96] coding_data_bits
  input  logic [103:0] s_axis_tdata,
  // [2:0] command
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [2:0] ep0_action, [6:3] reply_source, [13:7] reply_length,
  // [69:14] reply_inline, [72:70] endpoint_action, [73] address_apply,
  // [80:74] device_address, [82:81] transmit_status, [83] is_configured,
  // [87:84] zero
  output logic [87:0]  m_axis_tdata
);

  // Input register
  logic               in_valid;
  ucdc_pkg::cmd_t     in_cmd;
  logic [103:0]       in_data;

  // Endpoint state
  logic        configured, configured_next;
  logic [7:0]  config_num, config_num_next;
  logic [6:0]  pending_addr, pending_addr_next;
  logic        expect_coding, expect_coding_next;
  logic [31:0] line_rate, line_rate_next;
  logic [7:0]  line_stop, line_stop_next;
  logic [7:0]  line_parity, line_parity_next;
  logic [7:0]  line_data_bits, line_data_bits_next;
  logic        tx_busy, tx_busy_next;

  // Result fields
  ucdc_pkg::ep0_act_t ep0_act;
  ucdc_pkg::src_t     src;
  logic [6:0]         rep_len;
  logic [55:0]        rep_inline;
  ucdc_pkg::ep_act_t  ep_act;
  logic               addr_apply;
  logic [6:0]         dev_addr;
  ucdc_pkg::tx_stat_t tx_stat;

  // Result register
  logic        out_valid;
  logic [87:0] out_data;

  logic advance;

  // Unpacked request fields
  logic [7:0]  rtype, rcode;
  logic [15:0] rvalue, rlen;
  logic [31:0] c_rate;
  logic [7:0]  c_stop, c_parity, c_bits;
  logic [1:0]  kind;
  logic [4:0]  recip;
  logic [7:0]  dtype, didx;

  assign rtype    = in_data[7:0];
  assign rcode    = in_data[15:8];
  assign rvalue   = in_data[31:16];
  assign rlen     = in_data[47:32];
  assign c_rate   = in_data[79:48];
  assign c_stop   = in_data[87:80];
  assign c_parity = in_data[95:88];
  assign c_bits   = in_data[103:96];
  assign kind     = rtype[6:5];
  assign recip    = rtype[4:0];
  assign dtype    = rvalue[15:8];
  assign didx     = rvalue[7:0];

  // Move the input word on when the result register is free or draining
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // Decode one event against the current state
  always_comb begin
    configured_next     = configured;
    config_num_next     = config_num;
    pending_addr_next   = pending_addr;
    expect_coding_next  = expect_coding;
    line_rate_next      = line_rate;
    line_stop_next      = line_stop;
    line_parity_next    = line_parity;
    line_data_bits_next = line_data_bits;
    tx_busy_next        = tx_busy;

    ep0_act    = ucdc_pkg::EP0_NONE;
    src        = ucdc_pkg::SRC_NONE;
    rep_len    = 7'd0;
    rep_inline = 56'd0;
    ep_act     = ucdc_pkg::EPA_NONE;
    addr_apply = 1'b0;
    dev_addr   = 7'd0;
    tx_stat    = ucdc_pkg::TX_NONE;

    case (in_cmd)
      ucdc_pkg::CMD_SETUP: begin
        // Any setup drops a pending line coding
        expect_coding_next = 1'b0;
        ep0_act = ucdc_pkg::EP0_STALL;
        if (kind == ucdc_pkg::KIND_STANDARD && recip == ucdc_pkg::RCP_DEVICE) begin
          case (rcode)
            ucdc_pkg::REQ_GET_DESC: begin
              ep0_act = ucdc_pkg::EP0_SEND;
              if (dtype == ucdc_pkg::DESC_DEVICE) begin
                src     = ucdc_pkg::SRC_DEVICE;
                rep_len = ucdc_pkg::clamp_len(ucdc_pkg::LEN_DEVICE, rlen);
              end else if (dtype == ucdc_pkg::DESC_CONFIG) begin
                src     = ucdc_pkg::SRC_CONFIG;
                rep_len = ucdc_pkg::clamp_len(ucdc_pkg::LEN_CONFIG, rlen);
              end else if (dtype == ucdc_pkg::DESC_QUAL) begin
                src     = ucdc_pkg::SRC_QUAL;
                rep_len = ucdc_pkg::clamp_len(ucdc_pkg::LEN_QUAL, rlen);
              end else if (dtype == ucdc_pkg::DESC_STRING &&
                           didx < 8'(ucdc_pkg::NUM_STRINGS)) begin
                src     = ucdc_pkg::src_t'(ucdc_pkg::SRC_STRING0 + {2'd0, didx[1:0]});
                rep_len = ucdc_pkg::clamp_len(ucdc_pkg::string_len(didx[1:0]), rlen);
              end else begin
                ep0_act = ucdc_pkg::EP0_STALL;
              end
            end
            ucdc_pkg::REQ_SET_ADDRESS: begin
              pending_addr_next = rvalue[6:0];
              ep0_act = ucdc_pkg::EP0_ZLP;
            end
            ucdc_pkg::REQ_SET_CONFIG: begin
              config_num_next = rvalue[7:0];
              if (rvalue[7:0] == 8'd1) begin
                configured_next = 1'b1;
                ep_act = ucdc_pkg::EPA_OPEN;
              end else begin
                configured_next = 1'b0;
                ep_act = ucdc_pkg::EPA_CLOSE;
              end
              ep0_act = ucdc_pkg::EP0_ZLP;
            end
            ucdc_pkg::REQ_GET_CONFIG: begin
              ep0_act    = ucdc_pkg::EP0_SEND;
              src        = ucdc_pkg::SRC_CFG_VAL;
              rep_len    = ucdc_pkg::clamp_len(ucdc_pkg::LEN_CFG_VAL, rlen);
              rep_inline = {48'd0, config_num};
            end
            ucdc_pkg::REQ_GET_STATUS: begin
              ep0_act = ucdc_pkg::EP0_SEND;
              src     = ucdc_pkg::SRC_STATUS;
              rep_len = ucdc_pkg::clamp_len(ucdc_pkg::LEN_STATUS, rlen);
            end
            ucdc_pkg::REQ_CLEAR_FEATURE, ucdc_pkg::REQ_SET_FEATURE: begin
              ep0_act = ucdc_pkg::EP0_ZLP;
            end
            default: ep0_act = ucdc_pkg::EP0_STALL;
          endcase
        end else if (kind == ucdc_pkg::KIND_STANDARD &&
                     recip == ucdc_pkg::RCP_INTERFACE) begin
          if (rcode == ucdc_pkg::REQ_GET_IFACE) begin
            ep0_act = ucdc_pkg::EP0_SEND;
            src     = ucdc_pkg::SRC_ALT;
            rep_len = ucdc_pkg::clamp_len(ucdc_pkg::LEN_ALT, rlen);
          end else if (rcode == ucdc_pkg::REQ_SET_IFACE) begin
            ep0_act = ucdc_pkg::EP0_ZLP;
          end
        end else if (kind == ucdc_pkg::KIND_CLASS) begin
          // Class requests ignore the recipient bits
          case (rcode)
            ucdc_pkg::REQ_SET_LINE_CODING: begin
              if (rlen == 16'(ucdc_pkg::LEN_LINECODE)) begin
                expect_coding_next = 1'b1;
                ep0_act = ucdc_pkg::EP0_ARM7;
              end
            end
            ucdc_pkg::REQ_GET_LINE_CODING: begin
              ep0_act    = ucdc_pkg::EP0_SEND;
              src        = ucdc_pkg::SRC_LINECODE;
              rep_len    = ucdc_pkg::clamp_len(ucdc_pkg::LEN_LINECODE, rlen);
              rep_inline = {line_data_bits, line_parity, line_stop, line_rate};
            end
            ucdc_pkg::REQ_SET_CTRL_LINE, ucdc_pkg::REQ_SEND_BREAK: begin
              ep0_act = ucdc_pkg::EP0_ZLP;
            end
            default: ep0_act = ucdc_pkg::EP0_STALL;
          endcase
        end
      end
      ucdc_pkg::CMD_EP0_IN: begin
        // Apply the pending address after the status stage
        if (pending_addr != 7'd0) begin
          addr_apply        = 1'b1;
          dev_addr          = pending_addr;
          pending_addr_next = 7'd0;
        end
      end
      ucdc_pkg::CMD_EP0_OUT: begin
        if (expect_coding) begin
          line_rate_next      = (c_rate == 32'd0) ? ucdc_pkg::DEFAULT_RATE : c_rate;
          line_stop_next      = c_stop;
          line_parity_next    = c_parity;
          line_data_bits_next = c_bits;
          expect_coding_next  = 1'b0;
          ep0_act = ucdc_pkg::EP0_ZLP;
        end
      end
      ucdc_pkg::CMD_DATA_IN: tx_busy_next = 1'b0;
      ucdc_pkg::CMD_BUS_RESET: begin
        configured_next   = 1'b0;
        config_num_next   = 8'd0;
        pending_addr_next = 7'd0;
        ep_act = ucdc_pkg::EPA_EP0;
      end
      ucdc_pkg::CMD_DISCONN: configured_next = 1'b0;
      ucdc_pkg::CMD_TRANSMIT: begin
        if (!configured || tx_busy || rlen == 16'd0) begin
          tx_stat = ucdc_pkg::TX_REFUSED;
        end else begin
          tx_busy_next = 1'b1;
          tx_stat = ucdc_pkg::TX_ACCEPT;
        end
      end
      default: ep_act = ucdc_pkg::EPA_REARM;
    endcase
  end

  // Input register: take a word whenever the stage is empty or moving on
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd  <= ucdc_pkg::cmd_t'(s_axis_tuser);
      in_data <= s_axis_tdata;
    end
  end

  // Result register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= {4'd0, configured_next, tx_stat, dev_addr, addr_apply, ep_act,
                   rep_inline, rep_len, src, ep0_act};
    end
  end

  // Commit state as the word leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      configured     <= 1'b0;
      config_num     <= 8'd0;
      pending_addr   <= 7'd0;
      expect_coding  <= 1'b0;
      line_rate      <= ucdc_pkg::DEFAULT_RATE;
      line_stop      <= 8'd0;
      line_parity    <= 8'd0;
      line_data_bits <= ucdc_pkg::DEFAULT_DATA_BITS;
      tx_busy        <= 1'b0;
    end else if (advance) begin
      configured     <= configured_next;
      config_num     <= config_num_next;
      pending_addr   <= pending_addr_next;
      expect_coding  <= expect_coding_next;
      line_rate      <= line_rate_next;
      line_stop      <= line_stop_next;
      line_parity    <= line_parity_next;
      line_data_bits <= line_data_bits_next;
      tx_busy        <= tx_busy_next;
    end
  end

  // An applied address is never zero
  `ASSERT_SAME(a_addr_nonzero, clk, rst, out_valid && out_data[73], out_data[80:74] != 7'd0)
  // Reply length only accompanies a data stage, and never passes the config size
  `ASSERT_SAME(a_len_send, clk, rst,
               out_valid && out_data[13:7] != 7'd0,
               out_data[2:0] == ucdc_pkg::EP0_SEND && out_data[13:7] <= ucdc_pkg::LEN_CONFIG)
  // Reported configured flag matches the committed state
  `ASSERT_NEXT(a_cfg_flag, clk, rst, advance, out_data[83] == configured)
  // An accepted transmit leaves the endpoint busy
  `ASSERT_NEXT(a_tx_busy, clk, rst, advance && tx_stat == ucdc_pkg::TX_ACCEPT, tx_busy)
  // The stored line rate is never zero
  `ASSERT_SAME(a_rate_nonzero, clk, rst, 1'b1, line_rate != 32'd0)

endmodule

[sim/tb_usb_cdc_control_endpoint.sv]
// Self-checking testbench for the USB CDC control endpoint event decoder.
`timescale 1ns / 1ps

module tb_usb_cdc_control_endpoint;
  import ucdc_pkg::*;

  localparam logic [1:0] KIND_VENDOR = 2'b10;
  localparam int unsigned STUCK_LIMIT = 5000;
  localparam int unsigned PHASE_ITEMS = 540;

  // One host event, packed as {tdata, tuser}
  typedef struct packed {
    logic [7:0]  data_bits;
    logic [7:0]  parity;
    logic [7:0]  stop_bits;
    logic [31:0] rate;
    logic [15:0] length;
    logic [15:0] value;
    logic [7:0]  code;
    logic [7:0]  rtype;
    cmd_t        command;
  } ctl_event_t;

  // One endpoint reply, packed as m_axis_tdata[83:0]
  typedef struct packed {
    logic        cfg_flag;
    tx_stat_t    tx;
    logic [6:0]  dev_addr;
    logic        addr_apply;
    ep_act_t     ep_act;
    logic [55:0] bytes_le;
    logic [6:0]  len;
    src_t        src;
    ep0_act_t    ep0;
  } reply_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [87:0]  m_axis_tdata;

  usb_cdc_control_endpoint i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  ctl_event_t  host_events[$];
  reply_t      expected_replies[$];
  int unsigned queued_items = 0;
  int unsigned send_idle_pct = 31;
  int unsigned recv_idle_pct = 51;
  int unsigned fail_count = 0;
  int unsigned stuck_cycles = 0;
  logic        in_taken = 1'b0;

  // Endpoint state as the host sees it
  logic        dev_configured = 1'b0;
  logic [7:0]  dev_config_value = '0;
  logic [6:0]  addr_pending = '0;
  logic        coding_expected = 1'b0;
  logic [31:0] baud_rate = DEFAULT_RATE;
  logic [7:0]  char_format = '0;
  logic [7:0]  parity_type = '0;
  logic [7:0]  data_bits = DEFAULT_DATA_BITS;
  logic        tx_busy = 1'b0;

  function automatic reply_t data_stage(input src_t src, input logic [6:0] size,
                                        input logic [15:0] wlen, input logic [55:0] bytes);
    reply_t r;
    r = '0;
    r.ep0 = EP0_SEND;
    r.src = src;
    r.len = (wlen < 16'(size)) ? wlen[6:0] : size;
    r.bytes_le = bytes;
    return r;
  endfunction

  function automatic reply_t descriptor_reply(input logic [15:0] value, input logic [15:0] wlen);
    reply_t r;
    r = '0;
    r.ep0 = EP0_STALL;
    case (value[15:8])
      DESC_DEVICE: r = data_stage(SRC_DEVICE, LEN_DEVICE, wlen, '0);
      DESC_CONFIG: r = data_stage(SRC_CONFIG, LEN_CONFIG, wlen, '0);
      DESC_QUAL:   r = data_stage(SRC_QUAL, LEN_QUAL, wlen, '0);
      DESC_STRING: begin
        case (value[7:0])
          8'd0: r = data_stage(SRC_STRING0, 7'd4, wlen, '0);
          8'd1: r = data_stage(src_t'(SRC_STRING0 + 4'd1), 7'd14, wlen, '0);
          8'd2: r = data_stage(src_t'(SRC_STRING0 + 4'd2), 7'd26, wlen, '0);
          8'd3: r = data_stage(src_t'(SRC_STRING0 + 4'd3), 7'd10, wlen, '0);
          default: ;
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  // Advance the endpoint state by one event and return the reply it causes
  function automatic reply_t endpoint_reply(input ctl_event_t ev);
    reply_t r;
    r = '0;
    case (ev.command)
      CMD_SETUP: begin
        coding_expected = 1'b0;
        if (ev.rtype[6:5] == KIND_STANDARD && ev.rtype[4:0] == RCP_DEVICE) begin
          case (ev.code)
            REQ_GET_DESC: r = descriptor_reply(ev.value, ev.length);
            REQ_SET_ADDRESS: begin
              addr_pending = ev.value[6:0];
              r.ep0 = EP0_ZLP;
            end
            REQ_SET_CONFIG: begin
              dev_config_value = ev.value[7:0];
              dev_configured = (dev_config_value == 8'd1);
              r.ep_act = dev_configured ? EPA_OPEN : EPA_CLOSE;
              r.ep0 = EP0_ZLP;
            end
            REQ_GET_CONFIG:
              r = data_stage(SRC_CFG_VAL, LEN_CFG_VAL, ev.length, 56'(dev_config_value));
            REQ_GET_STATUS: r = data_stage(SRC_STATUS, LEN_STATUS, ev.length, '0);
            REQ_CLEAR_FEATURE, REQ_SET_FEATURE: r.ep0 = EP0_ZLP;
            default: r.ep0 = EP0_STALL;
          endcase
        end else if (ev.rtype[6:5] == KIND_STANDARD && ev.rtype[4:0] == RCP_INTERFACE) begin
          if (ev.code == REQ_GET_IFACE) r = data_stage(SRC_ALT, LEN_ALT, ev.length, '0);
          else if (ev.code == REQ_SET_IFACE) r.ep0 = EP0_ZLP;
          else r.ep0 = EP0_STALL;
        end else if (ev.rtype[6:5] == KIND_CLASS) begin
          // class requests ignore the recipient bits
          case (ev.code)
            REQ_SET_LINE_CODING: begin
              if (ev.length == 16'd7) begin
                coding_expected = 1'b1;
                r.ep0 = EP0_ARM7;
              end else begin
                r.ep0 = EP0_STALL;
              end
            end
            REQ_GET_LINE_CODING:
              r = data_stage(SRC_LINECODE, LEN_LINECODE, ev.length,
                             {data_bits, parity_type, char_format, baud_rate});
            REQ_SET_CTRL_LINE, REQ_SEND_BREAK: r.ep0 = EP0_ZLP;
            default: r.ep0 = EP0_STALL;
          endcase
        end else begin
          r.ep0 = EP0_STALL;
        end
      end
      CMD_EP0_IN: begin
        if (addr_pending != 7'd0) begin
          r.addr_apply = 1'b1;
          r.dev_addr = addr_pending;
          addr_pending = '0;
        end
      end
      CMD_EP0_OUT: begin
        if (coding_expected) begin
          baud_rate = (ev.rate == 32'd0) ? DEFAULT_RATE : ev.rate;
          char_format = ev.stop_bits;
          parity_type = ev.parity;
          data_bits = ev.data_bits;
          coding_expected = 1'b0;
          r.ep0 = EP0_ZLP;
        end
      end
      CMD_DATA_IN: tx_busy = 1'b0;
      CMD_BUS_RESET: begin
        dev_configured = 1'b0;
        dev_config_value = '0;
        addr_pending = '0;
        r.ep_act = EPA_EP0;
      end
      CMD_DISCONN: dev_configured = 1'b0;
      CMD_TRANSMIT: begin
        if (!dev_configured || tx_busy || ev.length == 16'd0) begin
          r.tx = TX_REFUSED;
        end else begin
          tx_busy = 1'b1;
          r.tx = TX_ACCEPT;
        end
      end
      default: r.ep_act = EPA_REARM;
    endcase
    r.cfg_flag = dev_configured;
    return r;
  endfunction

  function automatic ctl_event_t random_event();
    ctl_event_t ev;
    ev.command = cmd_t'(3'($urandom));
    ev.rtype = 8'($urandom);
    ev.code = 8'($urandom);
    ev.value = 16'($urandom);
    ev.length = 16'($urandom);
    ev.rate = $urandom;
    ev.stop_bits = 8'($urandom);
    ev.parity = 8'($urandom);
    ev.data_bits = 8'($urandom);
    return ev;
  endfunction

  function automatic ctl_event_t event_of(input cmd_t cmd);
    ctl_event_t ev;
    ev = random_event();
    ev.command = cmd;
    return ev;
  endfunction

  function automatic ctl_event_t setup_ev(input logic [7:0] rtype, input logic [7:0] code,
                                          input logic [15:0] value, input logic [15:0] wlen);
    ctl_event_t ev;
    ev = event_of(CMD_SETUP);
    ev.rtype = rtype;
    ev.code = code;
    ev.value = value;
    ev.length = wlen;
    return ev;
  endfunction

  // Random direction bit, given type and recipient
  function automatic logic [7:0] req_type(input logic [1:0] kind, input logic [4:0] recip);
    return {1'($urandom), kind, recip};
  endfunction

  function automatic logic [15:0] pick_length();
    logic [15:0] len;
    case ($urandom_range(0, 5))
      0: len = 16'd0;
      1: len = 16'd7;
      2: len = 16'($urandom_range(1, 80));
      3: len = 16'hFFFF;
      default: len = 16'($urandom);
    endcase
    return len;
  endfunction

  task automatic post(input ctl_event_t ev);
    host_events.push_back(ev);
    queued_items++;
  endtask

  // Mostly well-formed request sequences with random content, some noise
  task automatic queue_traffic(input int unsigned target);
    ctl_event_t ev;
    logic [7:0] code;
    logic [4:0] recip;
    int unsigned n;
    while (queued_items < target) begin
      case ($urandom_range(0, 9))
        0: begin
          post(event_of(CMD_BUS_RESET));
          post(setup_ev(req_type(KIND_STANDARD, RCP_DEVICE), REQ_GET_DESC,
                        {DESC_DEVICE, 8'($urandom)}, pick_length()));
          post(setup_ev(req_type(KIND_STANDARD, RCP_DEVICE), REQ_SET_ADDRESS,
                        16'($urandom), pick_length()));
          post(event_of(CMD_EP0_IN));
          post(setup_ev(req_type(KIND_STANDARD, RCP_DEVICE), REQ_GET_DESC,
                        {DESC_CONFIG, 8'd0}, pick_length()));
          post(setup_ev(req_type(KIND_STANDARD, RCP_DEVICE), REQ_SET_CONFIG,
                        ($urandom_range(0, 4) != 0) ? 16'd1 : 16'($urandom), pick_length()));
          post(setup_ev(req_type(KIND_STANDARD, RCP_DEVICE), REQ_GET_CONFIG,
                        16'($urandom), pick_length()));
        end
        1, 2: begin
          post(setup_ev(req_type(KIND_CLASS, 5'($urandom)), REQ_SET_LINE_CODING,
                        16'($urandom), ($urandom_range(0, 5) != 0) ? 16'd7 : pick_length()));
          // an intervening setup drops the expected coding
          if ($urandom_range(0, 5) == 0)
            post(setup_ev(req_type(KIND_CLASS, 5'($urandom)), REQ_SET_CTRL_LINE,
                          16'($urandom), pick_length()));
          ev = event_of(CMD_EP0_OUT);
          if ($urandom_range(0, 7) == 0) ev.rate = '0;
          post(ev);
          post(setup_ev(req_type(KIND_CLASS, 5'($urandom)), REQ_GET_LINE_CODING,
                        16'($urandom), pick_length()));
        end
        3, 4: begin
          if ($urandom_range(0, 2) == 0)
            post(setup_ev(req_type(KIND_STANDARD, RCP_DEVICE), REQ_SET_CONFIG, 16'd1,
                          pick_length()));
          n = $urandom_range(1, 6);
          repeat (n) begin
            ev = event_of(CMD_TRANSMIT);
            if ($urandom_range(0, 7) == 0) ev.length = '0;
            post(ev);
            case ($urandom_range(0, 2))
              0: post(event_of(CMD_DATA_IN));
              1: post(event_of(CMD_DATA_OUT));
              default: ;
            endcase
          end
        end
        5, 6: begin
          case ($urandom_range(0, 9))
            0: code = REQ_GET_STATUS;
            1: code = REQ_CLEAR_FEATURE;
            2: code = REQ_SET_FEATURE;
            3: code = REQ_GET_CONFIG;
            4: code = REQ_SET_CONFIG;
            5: code = REQ_GET_IFACE;
            6: code = REQ_SET_IFACE;
            7: code = REQ_SET_ADDRESS;
            8: code = REQ_GET_DESC;
            default: code = 8'($urandom);
          endcase
          if ($urandom_range(0, 3) == 0) recip = 5'($urandom);
          else if (code == REQ_GET_IFACE || code == REQ_SET_IFACE) recip = RCP_INTERFACE;
          else recip = RCP_DEVICE;
          post(setup_ev(req_type(KIND_STANDARD, recip), code,
                        (code == REQ_SET_CONFIG) ? 16'($urandom_range(0, 2)) : 16'($urandom),
                        pick_length()));
        end
        7: post(setup_ev(req_type(KIND_STANDARD, RCP_DEVICE), REQ_GET_DESC,
                         {8'($urandom_range(0, 7)), 8'($urandom_range(0, 5))}, pick_length()));
        8: post(random_event());
        default: begin
          case ($urandom_range(0, 4))
            0: post(event_of(CMD_DISCONN));
            1: post(event_of(CMD_EP0_IN));
            2: post(event_of(CMD_EP0_OUT));
            3: post(event_of(CMD_BUS_RESET));
            default: post(setup_ev(req_type(KIND_CLASS, 5'($urandom)),
                                   8'($urandom_range(8'h1E, 8'h25)), 16'($urandom),
                                   pick_length()));
          endcase
        end
      endcase
    end
  endtask

  // Hold until every queued event went in and every reply came out
  task automatic wait_for_drain();
    do @(negedge clk);
    while (host_events.size() != 0 || s_axis_tvalid || expected_replies.size() != 0);
  endtask

  // Driver: present the next event at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      if (!s_axis_tvalid || in_taken) begin
        if (host_events.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          {s_axis_tdata, s_axis_tuser} <= host_events.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor: predict on each accepted event, check each accepted reply
  always @(posedge clk) begin : monitor
    reply_t got;
    reply_t want;
    if (rst) begin
      in_taken <= 1'b0;
      stuck_cycles <= 0;
    end else begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready)
        expected_replies.push_back(endpoint_reply(ctl_event_t'({s_axis_tdata, s_axis_tuser})));
      if (m_axis_tvalid && m_axis_tready) begin
        got = reply_t'(m_axis_tdata[83:0]);
        if (expected_replies.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected reply word %h", m_axis_tdata);
        end else begin
          want = expected_replies.pop_front();
          if (got.ep0 !== want.ep0 || got.src !== want.src || got.len !== want.len ||
              got.bytes_le !== want.bytes_le || got.ep_act !== want.ep_act ||
              got.addr_apply !== want.addr_apply || got.dev_addr !== want.dev_addr ||
              got.tx !== want.tx || got.cfg_flag !== want.cfg_flag) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("reply mismatch, expected: ep0 %0d src %0d len %0d bytes %h epa %0d",
                       want.ep0, want.src, want.len, want.bytes_le, want.ep_act,
                       " apply %0d addr %0d tx %0d cfg %0d",
                       want.addr_apply, want.dev_addr, want.tx, want.cfg_flag);
              $display("reply mismatch, actual:   ep0 %0d src %0d len %0d bytes %h epa %0d",
                       got.ep0, got.src, got.len, got.bytes_le, got.ep_act,
                       " apply %0d addr %0d tx %0d cfg %0d",
                       got.addr_apply, got.dev_addr, got.tx, got.cfg_flag);
            end
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  initial begin
    // directed: reply sizes and clamps, addressing, configuration, line coding, transmit
    post(setup_ev(req_type(KIND_STANDARD, RCP_DEVICE), REQ_GET_STATUS, 16'h0000, 16'hFFFF));
    post(setup_ev(req_type(KIND_STANDARD, RCP_DEVICE), REQ_GET_DESC, {DESC_DEVICE, 8'h00},
                  16'h0000));
    post(setup_ev(req_type(KIND_STANDARD, RCP_DEVICE), REQ_GET_DESC, {DESC_CONFIG, 8'h00},
                  16'hFFFF));
    post(setup_ev(req_type(KIND_STANDARD, RCP_DEVICE), REQ_GET_DESC, {DESC_QUAL, 8'h00},
                  16'd3));
    post(setup_ev(req_type(KIND_STANDARD, RCP_DEVICE), REQ_GET_DESC, {DESC_STRING, 8'd3},
                  16'hFFFF));
    post(setup_ev(req_type(KIND_STANDARD, RCP_DEVICE), REQ_GET_DESC, {DESC_STRING, 8'd4},
                  16'hFFFF));
    post(setup_ev(req_type(KIND_STANDARD, RCP_DEVICE), REQ_SET_ADDRESS, 16'hFFFF, 16'h0000));
    post(event_of(CMD_EP0_IN));
    post(event_of(CMD_EP0_IN));
    post(setup_ev(req_type(KIND_STANDARD, RCP_DEVICE), REQ_SET_CONFIG, 16'd1, 16'h0000));
    post(setup_ev(req_type(KIND_STANDARD, RCP_DEVICE), REQ_GET_CONFIG, 16'h0000, 16'hFFFF));
    post(setup_ev(req_type(KIND_STANDARD, RCP_INTERFACE), REQ_GET_IFACE, 16'h0000, 16'hFFFF));
    post(setup_ev(req_type(KIND_STANDARD, RCP_DEVICE), REQ_CLEAR_FEATURE, 16'h0000, 16'h0));
    post(setup_ev(req_type(KIND_STANDARD, RCP_DEVICE), 8'hFF, 16'hFFFF, 16'hFFFF));
    post(setup_ev(req_type(KIND_STANDARD, 5'h1F), REQ_GET_STATUS, 16'h0000, 16'hFFFF));
    post(setup_ev(req_type(KIND_VENDOR, RCP_DEVICE), REQ_GET_STATUS, 16'h0000, 16'hFFFF));
    post(setup_ev(req_type(KIND_CLASS, RCP_INTERFACE), REQ_SET_LINE_CODING, 16'h0, 16'd6));
    post(setup_ev(req_type(KIND_CLASS, 5'h1F), REQ_SET_LINE_CODING, 16'h0, 16'd7));
    post('{data_bits: 8'hFF, parity: 8'hFF, stop_bits: 8'hFF, rate: 32'd0, length: 16'hFFFF,
           value: 16'hFFFF, code: 8'hFF, rtype: 8'hFF, command: CMD_EP0_OUT});
    post(setup_ev(req_type(KIND_CLASS, RCP_INTERFACE), REQ_GET_LINE_CODING, 16'h0, 16'hFFFF));
    post(setup_ev(req_type(KIND_CLASS, RCP_INTERFACE), REQ_SET_CTRL_LINE, 16'h3, 16'h0));
    post(event_of(CMD_EP0_OUT));
    post('{data_bits: 8'h00, parity: 8'h00, stop_bits: 8'h00, rate: 32'hFFFF_FFFF,
           length: 16'h0000, value: 16'h0000, code: 8'h00, rtype: 8'h00, command: CMD_TRANSMIT});
    post('{data_bits: 8'h00, parity: 8'h00, stop_bits: 8'h00, rate: 32'd0,
           length: 16'hFFFF, value: 16'h0000, code: 8'h00, rtype: 8'h00, command: CMD_TRANSMIT});
    post(event_of(CMD_TRANSMIT));
    post(event_of(CMD_DATA_IN));
    post(event_of(CMD_DISCONN));
    post(event_of(CMD_TRANSMIT));

    queue_traffic(queued_items + PHASE_ITEMS);
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    wait_for_drain();
    send_idle_pct = 51;
    recv_idle_pct = 31;
    queue_traffic(queued_items + PHASE_ITEMS);
    wait_for_drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_traffic(queued_items + PHASE_ITEMS);
    wait_for_drain();

    // two-stage pipe: let any stray reply come out before the verdict
    repeat (6) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
